// ===== rtl/hbos_pkg.sv =====
// Package for the hierarchical bitmap ordered set: types, constants, microcode ROM, pickers.
`default_nettype none

package hbos_pkg;

  // Key universe split into groups of offsets
  localparam int KEY_BITS    = 8;
  localparam int LOW_BITS    = KEY_BITS / 2;
  localparam int HIGH_BITS   = KEY_BITS - LOW_BITS;
  localparam int GROUP_SIZE  = 1 << LOW_BITS;
  localparam int GROUP_COUNT = 1 << HIGH_BITS;

  // Stream widths
  localparam int REQ_W       = 3;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_KEY_W   = 8;
  localparam int OUT_DATA_W  = 16;

  // Microprogram
  localparam int UPC_W       = 5;
  localparam int PROG_LEN    = 19;

  typedef logic [GROUP_SIZE-1:0]  row_t;
  typedef logic [GROUP_COUNT-1:0] sum_t;
  typedef logic [LOW_BITS-1:0]    ofs_t;
  typedef logic [HIGH_BITS-1:0]   grp_t;
  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [UPC_W-1:0]       upc_t;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_MEMBER = 3'd2,
    REQ_MIN    = 3'd3,
    REQ_MAX    = 3'd4,
    REQ_SUCC   = 3'd5,
    REQ_PRED   = 3'd6
  } req_e;

  // Micro-operations
  typedef enum logic [2:0] {
    U_NONE   = 3'd0,  // finish, nothing found
    U_RD_KEY = 3'd1,  // read the key's group row
    U_RD_SUM = 3'd2,  // search summary, read chosen row
    U_WR_INS = 3'd3,  // set key bit, write row back
    U_WR_DEL = 3'd4,  // clear key bit, write row back
    U_MEMB   = 3'd5,  // report key bit
    U_SCAN   = 3'd6   // search row just read
  } uop_e;

  typedef struct packed {
    uop_e op;
    logic down;    // search toward lower keys
    logic masked;  // restrict search to beyond the key
    logic jmp_en;  // on a miss, jump instead of finishing
    upc_t jmp;
  } cword_t;

  typedef struct packed {
    logic hit;
    ofs_t idx;
  } ofs_hit_t;

  typedef struct packed {
    logic hit;
    grp_t idx;
  } grp_hit_t;

  // Program entry points
  localparam upc_t E_INS   = 5'd0;
  localparam upc_t E_DEL   = 5'd2;
  localparam upc_t E_MEM   = 5'd4;
  localparam upc_t E_MIN   = 5'd6;
  localparam upc_t E_MAX   = 5'd8;
  localparam upc_t E_SUCC  = 5'd10;
  localparam upc_t E_SUCC2 = 5'd12;
  localparam upc_t E_PRED  = 5'd14;
  localparam upc_t E_PRED2 = 5'd16;
  localparam upc_t E_BAD   = 5'd18;

  function automatic cword_t mk(uop_e op, logic down, logic masked, logic jmp_en, upc_t jmp);
    cword_t c;
    c.op     = op;
    c.down   = down;
    c.masked = masked;
    c.jmp_en = jmp_en;
    c.jmp    = jmp;
    return c;
  endfunction

  // Control store
  function automatic cword_t ucode_rom(upc_t a);
    cword_t c;
    c = mk(U_NONE, 1'b0, 1'b0, 1'b0, E_INS);
    case (a)
      5'd0:  c = mk(U_RD_KEY, 1'b0, 1'b0, 1'b0, E_INS);
      5'd1:  c = mk(U_WR_INS, 1'b0, 1'b0, 1'b0, E_INS);
      5'd2:  c = mk(U_RD_KEY, 1'b0, 1'b0, 1'b0, E_INS);
      5'd3:  c = mk(U_WR_DEL, 1'b0, 1'b0, 1'b0, E_INS);
      5'd4:  c = mk(U_RD_KEY, 1'b0, 1'b0, 1'b0, E_INS);
      5'd5:  c = mk(U_MEMB,   1'b0, 1'b0, 1'b0, E_INS);
      5'd6:  c = mk(U_RD_SUM, 1'b0, 1'b0, 1'b0, E_INS);
      5'd7:  c = mk(U_SCAN,   1'b0, 1'b0, 1'b0, E_INS);
      5'd8:  c = mk(U_RD_SUM, 1'b1, 1'b0, 1'b0, E_INS);
      5'd9:  c = mk(U_SCAN,   1'b1, 1'b0, 1'b0, E_INS);
      5'd10: c = mk(U_RD_KEY, 1'b0, 1'b0, 1'b0, E_INS);
      5'd11: c = mk(U_SCAN,   1'b0, 1'b1, 1'b1, E_SUCC2);
      5'd12: c = mk(U_RD_SUM, 1'b0, 1'b1, 1'b0, E_INS);
      5'd13: c = mk(U_SCAN,   1'b0, 1'b0, 1'b0, E_INS);
      5'd14: c = mk(U_RD_KEY, 1'b0, 1'b0, 1'b0, E_INS);
      5'd15: c = mk(U_SCAN,   1'b1, 1'b1, 1'b1, E_PRED2);
      5'd16: c = mk(U_RD_SUM, 1'b1, 1'b1, 1'b0, E_INS);
      5'd17: c = mk(U_SCAN,   1'b1, 1'b0, 1'b0, E_INS);
      default: c = mk(U_NONE, 1'b0, 1'b0, 1'b0, E_INS);
    endcase
    return c;
  endfunction

  // Request code to program entry
  function automatic upc_t dispatch(logic [REQ_W-1:0] req);
    upc_t e;
    e = E_BAD;
    case (req)
      REQ_INSERT: e = E_INS;
      REQ_DELETE: e = E_DEL;
      REQ_MEMBER: e = E_MEM;
      REQ_MIN:    e = E_MIN;
      REQ_MAX:    e = E_MAX;
      REQ_SUCC:   e = E_SUCC;
      REQ_PRED:   e = E_PRED;
      default:    e = E_BAD;
    endcase
    return e;
  endfunction

  // Lowest set bit, or highest when down
  function automatic ofs_hit_t row_pick(row_t v, logic down);
    ofs_hit_t r;
    r = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (v[i] && (down || !r.hit)) begin
        r.hit = 1'b1;
        r.idx = ofs_t'(i);
      end
    end
    return r;
  endfunction

  function automatic grp_hit_t sum_pick(sum_t v, logic down);
    grp_hit_t r;
    r = '0;
    for (int i = 0; i < GROUP_COUNT; i++) begin
      if (v[i] && (down || !r.hit)) begin
        r.hit = 1'b1;
        r.idx = grp_t'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hierarchical_bitmap_ordered_set_unit.sv =====
// Ordered key set as group rows plus a summary word, run by a microcoded sequencer.
// Microsteps: 1 to 4 per request (insert/delete/member 2, min/max 1 or 2, successor/
// predecessor 2 to 4, unused code 1); result registered on the last step, which stalls on a held result.
// A new request is taken only once the previous one has finished; each step does at most one
// row read or one row write on the single-port group row memory.
// Reset: rst_ni clears the summary, the per-row valid bits and all control state,
// so the set is empty at once; no clearing pass.
`default_nettype none

module hierarchical_bitmap_ordered_set_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [hbos_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // [7:0] key
  input  wire logic [hbos_pkg::REQ_W-1:0]           s_axis_tuser,   // [2:0] req_type
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [hbos_pkg::OUT_DATA_W-1:0]           m_axis_tdata,   // [7:0] result_key,
                                                                    // [8] set_nonempty
  output logic                                      m_axis_tuser    // [0] found
);
  import hbos_pkg::*;

  // Sequencer state
  logic     busy_q, busy_d;
  upc_t     upc_q, upc_d;
  key_t     key_q;
  grp_t     grp_q, grp_d;
  sum_t     sum_q, sum_d;
  sum_t     row_valid_q;

  // Row memory and registered read port
  row_t     row_mem [GROUP_COUNT];
  row_t     rd_row_q;
  logic     rd_valid_q;
  logic     rd_en;
  grp_t     rd_addr;
  logic     wr_en;
  row_t     wr_row;

  // Result register
  logic     out_valid_q;
  logic     found_q;
  logic [OUT_KEY_W-1:0] res_key_q;
  logic     nonempty_q;

  // Step decode
  cword_t   cw;
  row_t     row_cur, row_bit, row_up, row_dn, scan_row;
  sum_t     sum_up, sum_dn, scan_sum;
  ofs_t     key_ofs;
  grp_t     key_grp;
  ofs_hit_t rp;
  grp_hit_t sp;
  logic     fin, fin_found;
  key_t     fin_key;
  logic     out_free, advance;

  assign cw      = ucode_rom(upc_q);
  assign key_ofs = key_q[LOW_BITS-1:0];
  assign key_grp = key_q[KEY_BITS-1:LOW_BITS];
  assign row_cur = rd_valid_q ? rd_row_q : '0;
  assign row_bit = row_t'(1) << key_ofs;

  // Search windows strictly beyond the key
  assign row_up   = row_t'(row_t'(~row_t'(0) << key_ofs) << 1);
  assign row_dn   = ~row_t'(~row_t'(0) << key_ofs);
  assign sum_up   = sum_t'(sum_t'(~sum_t'(0) << key_grp) << 1);
  assign sum_dn   = ~sum_t'(~sum_t'(0) << key_grp);
  assign scan_row = cw.masked ? (row_cur & (cw.down ? row_dn : row_up)) : row_cur;
  assign scan_sum = cw.masked ? (sum_q & (cw.down ? sum_dn : sum_up)) : sum_q;
  assign rp       = row_pick(scan_row, cw.down);
  assign sp       = sum_pick(scan_sum, cw.down);

  assign out_free = !out_valid_q || m_axis_tready;

  // Datapath control from the current control word
  always_comb begin
    fin       = 1'b0;
    fin_found = 1'b0;
    fin_key   = '0;
    rd_en     = 1'b0;
    rd_addr   = key_grp;
    wr_en     = 1'b0;
    wr_row    = row_cur;
    grp_d     = grp_q;
    upc_d     = upc_q + upc_t'(1);
    sum_d     = sum_q;
    unique case (cw.op)
      U_RD_KEY: begin
        rd_en   = 1'b1;
        rd_addr = key_grp;
        grp_d   = key_grp;
      end
      U_RD_SUM: begin
        if (sp.hit) begin
          rd_en   = 1'b1;
          rd_addr = sp.idx;
          grp_d   = sp.idx;
        end else begin
          fin = 1'b1;
        end
      end
      U_WR_INS: begin
        wr_en        = 1'b1;
        wr_row       = row_cur | row_bit;
        sum_d[grp_q] = 1'b1;
        fin          = 1'b1;
        fin_found    = |(row_cur & row_bit);
      end
      U_WR_DEL: begin
        wr_en        = 1'b1;
        wr_row       = row_cur & ~row_bit;
        sum_d[grp_q] = |(row_cur & ~row_bit);
        fin          = 1'b1;
        fin_found    = |(row_cur & row_bit);
      end
      U_MEMB: begin
        fin       = 1'b1;
        fin_found = |(row_cur & row_bit);
      end
      U_SCAN: begin
        if (rp.hit) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_key   = {grp_q, rp.idx};
        end else if (cw.jmp_en) begin
          upc_d = cw.jmp;
        end else begin
          fin = 1'b1;
        end
      end
      U_NONE: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // A finishing step waits for room in the result register
  assign advance       = busy_q && (!fin || out_free);
  assign s_axis_tready = !busy_q;

  always_comb begin
    busy_d = busy_q;
    if (s_axis_tvalid && s_axis_tready) begin
      busy_d = 1'b1;
    end else if (advance && fin) begin
      busy_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= '0;
      sum_q       <= '0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (s_axis_tvalid && s_axis_tready) begin
        upc_q <= dispatch(s_axis_tuser);
      end else if (advance) begin
        upc_q <= upc_d;
      end
      if (advance) begin
        sum_q <= sum_d;
        if (wr_en) begin
          row_valid_q[grp_q] <= 1'b1;
        end
        if (rd_en) begin
          rd_valid_q <= row_valid_q[rd_addr];
        end
      end
      if (advance && fin) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_q <= key_t'(s_axis_tdata);
    end
    if (advance) begin
      grp_q <= grp_d;
    end
    if (advance && fin) begin
      found_q    <= fin_found;
      res_key_q  <= OUT_KEY_W'(fin_key);
      nonempty_q <= |sum_d;
    end
  end

  // Group row memory, one access per step
  always_ff @(posedge clk_i) begin
    if (advance && wr_en) begin
      row_mem[grp_q] <= wr_row;
    end
    if (advance && rd_en) begin
      rd_row_q <= row_mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = found_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-OUT_KEY_W-1){1'b0}}, nonempty_q, res_key_q};

  // Checks
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> busy_q)
    else $error("request accepted but sequencer not busy");

  a_empty_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[OUT_KEY_W-1:0] == '0))
    else $error("result key not zero on empty answer");

  a_summary_del: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cw.op == U_WR_DEL) |=> (sum_q[$past(grp_q)] == (|$past(wr_row))))
    else $error("summary bit disagrees with row after delete");

  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (upc_q < upc_t'(PROG_LEN)))
    else $error("microprogram counter out of range");

endmodule

`default_nettype wire
